// ----- sv/cfp_pkg.sv -----
package cfp_pkg;

   // Grid dimensions.
   localparam int MAX_ROWS = 32;
   localparam int MAX_COLS = 32;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);

   // Counts hold values up to the larger dimension inclusive.
   localparam int CNT_W    = 6;
   localparam int WORD_W   = 16;
   localparam int STEP_W   = $clog2(WORD_W);
   localparam int STATUS_W = 2;

   // Configuration port.
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_IN_USE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COLS_IN_USE = CSR_IDX_W'(1);

   // Item actions.
   localparam logic ACT_FLIP  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_FLIPPED = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_FULL    = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_CLEARED = STATUS_W'(2);

   // Status returned by the shared remainder unit.
   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] remainder;
   } cfp_div_status_type;

   // Saturate a dimension register to the range 1..limit.
   function automatic logic [CNT_W-1:0] eff_dim(input logic [CNT_W-1:0] value,
                                               input logic [CNT_W-1:0] limit);
      logic [CNT_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = CNT_W'(1);
      end else if (value > limit) begin
         result = limit;
      end
      return result;
   endfunction

endpackage

// ----- sv/cfp_if.sv -----
// Input channel: one flip or clear item.
interface cfp_req_if;
   import cfp_pkg::*;
   logic              valid;
   logic              ready;
   logic              action;
   logic [WORD_W-1:0] random_row_word;
   logic [WORD_W-1:0] random_col_word;
   modport source (output valid, action, random_row_word, random_col_word, input ready);
   modport sink   (input valid, action, random_row_word, random_col_word, output ready);
endinterface

// Result channel: one result item per input item.
interface cfp_rsp_if;
   import cfp_pkg::*;
   logic                valid;
   logic                ready;
   logic [ROW_W-1:0]    row_index;
   logic [COL_W-1:0]    col_index;
   logic [STATUS_W-1:0] status;
   modport source (output valid, row_index, col_index, status, input ready);
   modport sink   (input valid, row_index, col_index, status, output ready);
endinterface

// Configuration write channel.
interface cfp_csr_if;
   import cfp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/cfp_mod_unit.sv -----
module cfp_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cfp_pkg::WORD_W-1:0]  dividend,
   input  logic [cfp_pkg::CNT_W-1:0]   divisor,
   output cfp_pkg::cfp_div_status_type status
);
   import cfp_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [CNT_W:0]    trial;

   // One restoring step per cycle, most significant dividend bit first.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[WORD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

// ----- sv/random_free_cell_picker_top.sv -----
// Random free cell picker over a grid of up to 32 by 32 cells.
// req_ch carries one item: a clear, or a flip with two random words.
// rsp_ch returns exactly one item for each input item: the chosen row and
// column with status flipped, status full when no free cell is left, or
// status cleared after a clear.
// csr_ch writes the rows and columns in use; a write to either register
// also clears the grid. It is always ready and is to be written only
// while the block is idle; the block does not enforce this. A flip runs
// the shared bit-serial remainder unit twice, and the row and column
// scans look at one entry per cycle. The next item can be accepted in
// the same cycle that the result appears. A clear or a flip on a full
// grid goes from idle straight to the done state. One item is worked on
// at a time; req_ch.ready is high only while the sequencer waits. The
// finished result sits in an output register, so the next item is
// accepted while it waits; a following result waits until that register
// has been taken. Reset sets 32 rows and 32 columns and frees every cell.
module random_free_cell_picker_top (
   input logic      clock,
   input logic      reset,
   cfp_req_if.sink  req_ch,
   cfp_rsp_if.source rsp_ch,
   cfp_csr_if.sink  csr_ch
);
   import cfp_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RMOD  = 3'd1;
   localparam logic [2:0] S_RWALK = 3'd2;
   localparam logic [2:0] S_CMOD  = 3'd3;
   localparam logic [2:0] S_CWALK = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   localparam logic [CNT_W-1:0] ROW_LIMIT = CNT_W'(MAX_ROWS);
   localparam logic [CNT_W-1:0] COL_LIMIT = CNT_W'(MAX_COLS);

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    rows_cfg_ff, rows_cfg_in;
   logic [CNT_W-1:0]    cols_cfg_ff, cols_cfg_in;
   logic [MAX_COLS-1:0] taken_ff [MAX_ROWS];
   logic [MAX_COLS-1:0] taken_in [MAX_ROWS];
   logic [CNT_W-1:0]    free_ff [MAX_ROWS];
   logic [CNT_W-1:0]    free_in [MAX_ROWS];
   logic [CNT_W-1:0]    rows_free_ff, rows_free_in;
   logic [WORD_W-1:0]   col_word_ff, col_word_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    seen_ff, seen_in;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [CNT_W-1:0]    sel_free_ff, sel_free_in;
   logic [MAX_COLS-1:0] row_bits_ff, row_bits_in;
   logic [ROW_W-1:0]    res_row_ff, res_row_in;
   logic [COL_W-1:0]    res_col_ff, res_col_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                do_clear;
   logic [CNT_W-1:0]    nr_eff, nc_eff, nr_new, nc_new;
   logic [CNT_W-1:0]    new_free;
   logic                div_start;
   logic [WORD_W-1:0]   div_dividend;
   logic [CNT_W-1:0]    div_divisor;
   cfp_div_status_type  div_status;

   // Shared remainder unit, used once for the row and once for the column.
   cfp_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status)
   );

   assign nr_eff = eff_dim(rows_cfg_ff, ROW_LIMIT);
   assign nc_eff = eff_dim(cols_cfg_ff, COL_LIMIT);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   // Sequencer, grid update and configuration writes.
   always_comb begin
      state_in      = state_ff;
      rows_cfg_in   = rows_cfg_ff;
      cols_cfg_in   = cols_cfg_ff;
      taken_in      = taken_ff;
      free_in       = free_ff;
      rows_free_in  = rows_free_ff;
      col_word_in   = col_word_ff;
      cnt_in        = cnt_ff;
      seen_in       = seen_ff;
      k_in          = k_ff;
      row_in        = row_ff;
      sel_free_in   = sel_free_ff;
      row_bits_in   = row_bits_ff;
      res_row_in    = res_row_ff;
      res_col_in    = res_col_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_status_in = rsp_status_ff;
      do_clear      = 1'b0;
      div_start     = 1'b0;
      div_dividend  = req_ch.random_row_word;
      div_divisor   = rows_free_ff;
      new_free      = sel_free_ff - CNT_W'(1);

      // The waiting result leaves when the receiver takes it.
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               col_word_in = req_ch.random_col_word;
               res_row_in  = '0;
               res_col_in  = '0;
               cnt_in      = '0;
               seen_in     = '0;
               if (req_ch.action == ACT_CLEAR) begin
                  do_clear      = 1'b1;
                  res_status_in = STATUS_CLEARED;
                  state_in      = S_DONE;
               end else if (rows_free_ff == '0) begin
                  res_status_in = STATUS_FULL;
                  state_in      = S_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_RMOD;
               end
            end
         end
         S_RMOD: begin
            if (div_status.done) begin
               k_in     = div_status.remainder;
               state_in = S_RWALK;
            end
         end
         S_RWALK: begin
            // Find the k-th row that still holds a free cell.
            div_dividend = col_word_ff;
            div_divisor  = free_ff[cnt_ff[ROW_W-1:0]];
            if (cnt_ff == nr_eff) begin
               res_status_in = STATUS_FULL;
               state_in      = S_DONE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (free_ff[cnt_ff[ROW_W-1:0]] != '0) begin
                  if (seen_ff == k_ff) begin
                     row_in      = cnt_ff[ROW_W-1:0];
                     sel_free_in = free_ff[cnt_ff[ROW_W-1:0]];
                     row_bits_in = taken_ff[cnt_ff[ROW_W-1:0]];
                     div_start   = 1'b1;
                     cnt_in      = '0;
                     seen_in     = '0;
                     state_in    = S_CMOD;
                  end else begin
                     seen_in = seen_ff + CNT_W'(1);
                  end
               end
            end
         end
         S_CMOD: begin
            if (div_status.done) begin
               k_in     = div_status.remainder;
               state_in = S_CWALK;
            end
         end
         S_CWALK: begin
            // Find the k-th free column of the chosen row and take it.
            if (cnt_ff == nc_eff) begin
               res_status_in = STATUS_FULL;
               state_in      = S_DONE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (!row_bits_ff[cnt_ff[COL_W-1:0]]) begin
                  if (seen_ff == k_ff) begin
                     taken_in[row_ff][cnt_ff[COL_W-1:0]] = 1'b1;
                     free_in[row_ff] = new_free;
                     if (new_free == '0) begin
                        rows_free_in = rows_free_ff - CNT_W'(1);
                     end
                     res_row_in    = row_ff;
                     res_col_in    = cnt_ff[COL_W-1:0];
                     res_status_in = STATUS_FLIPPED;
                     state_in      = S_DONE;
                  end else begin
                     seen_in = seen_ff + CNT_W'(1);
                  end
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_row_in    = res_row_ff;
               rsp_col_in    = res_col_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A write to either register sets its dimension and clears the grid.
      if (csr_ch.valid) begin
         if (csr_ch.index == REG_ROWS_IN_USE) begin
            rows_cfg_in = CNT_W'(csr_ch.data);
            do_clear    = 1'b1;
         end else if (csr_ch.index == REG_COLS_IN_USE) begin
            cols_cfg_in = CNT_W'(csr_ch.data);
            do_clear    = 1'b1;
         end
      end

      // The dimensions that apply once this cycle's write has landed.
      nr_new = eff_dim(rows_cfg_in, ROW_LIMIT);
      nc_new = eff_dim(cols_cfg_in, COL_LIMIT);

      // Free every cell with the dimensions that now apply.
      if (do_clear) begin
         for (int i = 0; i < MAX_ROWS; i++) begin
            taken_in[i] = '0;
            free_in[i]  = (CNT_W'(i) < nr_new) ? nc_new : '0;
         end
         rows_free_in = nr_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_cfg_ff  <= ROW_LIMIT;
         cols_cfg_ff  <= COL_LIMIT;
         rows_free_ff <= ROW_LIMIT;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ROWS; i++) begin
            taken_ff[i] <= '0;
            free_ff[i]  <= COL_LIMIT;
         end
      end else begin
         state_ff     <= state_in;
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         rows_free_ff <= rows_free_in;
         rsp_valid_ff <= rsp_valid_in;
         taken_ff     <= taken_in;
         free_ff      <= free_in;
      end
      col_word_ff   <= col_word_in;
      cnt_ff        <= cnt_in;
      seen_ff       <= seen_in;
      k_ff          <= k_in;
      row_ff        <= row_in;
      sel_free_ff   <= sel_free_in;
      row_bits_ff   <= row_bits_in;
      res_row_ff    <= res_row_in;
      res_col_ff    <= res_col_in;
      res_status_ff <= res_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.row_index = rsp_row_ff;
   assign rsp_ch.col_index = rsp_col_ff;
   assign rsp_ch.status    = rsp_status_ff;

endmodule

// ----- sv/cfp_checker.sv -----
module cfp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cfp_pkg::ROW_W-1:0]     rsp_row_index,
   input logic [cfp_pkg::COL_W-1:0]     rsp_col_index,
   input logic [cfp_pkg::STATUS_W-1:0]  rsp_status
);
   import cfp_pkg::*;

   // A stalled result holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_index)
         && $stable(rsp_col_index) && $stable(rsp_status))
      else $error("stalled result changed");

   // Only one item is in work: no second item right after an accepted one.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready straight after an accepted item");

   // Results that flip nothing carry zero coordinates and a known status.
   a_zero_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL || rsp_status == STATUS_CLEARED)
         |-> rsp_row_index == '0 && rsp_col_index == '0)
      else $error("coordinates set on a result without a flip");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_FLIPPED || rsp_status == STATUS_FULL
         || rsp_status == STATUS_CLEARED)
      else $error("unknown result status");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind random_free_cell_picker_top cfp_checker u_cfp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_row_index (rsp_ch.row_index),
   .rsp_col_index (rsp_ch.col_index),
   .rsp_status    (rsp_ch.status)
);

// ----- sim/tb_random_free_cell_picker_top.sv -----
`timescale 1ns / 1ps

module tb_random_free_cell_picker_top;
   import cfp_pkg::*;

   // Register indexes beyond the two that exist; writes to them must be ignored.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LOW = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_TOP = '1;

   // Directed items come first, then random grids until this many items in all.
   localparam int TOTAL_ITEMS     = 540;
   localparam int MAX_PHASE_FLIPS = 60;

   typedef struct packed {
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
      logic [STATUS_W-1:0] status;
   } cell_result_type;

   logic clock;
   logic reset;

   cfp_req_if req_ch ();
   cfp_rsp_if rsp_ch ();
   cfp_csr_if csr_ch ();

   random_free_cell_picker_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predicted grid: taken cells, free cells per row and rows not yet full.
   logic [MAX_COLS-1:0] taken_map [MAX_ROWS];
   int                  free_in_row [MAX_ROWS];
   int                  open_rows;
   logic [CNT_W-1:0]    row_setting;
   logic [CNT_W-1:0]    col_setting;

   cell_result_type expected_cells [$];
   int              fail_count;
   int              items_sent;
   bit              calm;

   // A dimension register is saturated to the range 1..limit.
   function automatic int clamp_dim(input logic [CNT_W-1:0] value, input int limit);
      if (value == '0) begin
         return 1;
      end
      if (int'(value) > limit) begin
         return limit;
      end
      return int'(value);
   endfunction

   // Free every cell and reload the counts from the dimensions in use.
   function automatic void free_all_cells();
      int nr;
      int nc;
      nr = clamp_dim(row_setting, MAX_ROWS);
      nc = clamp_dim(col_setting, MAX_COLS);
      for (int r = 0; r < MAX_ROWS; r++) begin
         taken_map[r]   = '0;
         free_in_row[r] = (r < nr) ? nc : 0;
      end
      open_rows = nr;
   endfunction

   // Apply one item to the predicted grid and return the result it causes.
   function automatic cell_result_type pick_free_cell(input logic act,
                                                      input logic [WORD_W-1:0] rw,
                                                      input logic [WORD_W-1:0] cw);
      cell_result_type res;
      int              nr;
      int              nc;
      int              k;
      int              seen;
      int              row;
      int              col;
      bit              found;
      res = '0;
      nr  = clamp_dim(row_setting, MAX_ROWS);
      nc  = clamp_dim(col_setting, MAX_COLS);
      if (act == ACT_CLEAR) begin
         free_all_cells();
         res.status = STATUS_CLEARED;
         return res;
      end
      res.status = STATUS_FULL;
      if (open_rows == 0) begin
         return res;
      end
      // The k-th row that still has a free cell.
      k     = int'(rw) % open_rows;
      seen  = 0;
      row   = 0;
      found = 1'b0;
      for (int r = 0; r < nr && !found; r++) begin
         if (free_in_row[r] != 0) begin
            if (seen == k) begin
               row   = r;
               found = 1'b1;
            end else begin
               seen++;
            end
         end
      end
      if (!found) begin
         return res;
      end
      // The k-th free column within that row.
      k     = int'(cw) % free_in_row[row];
      seen  = 0;
      col   = 0;
      found = 1'b0;
      for (int c = 0; c < nc && !found; c++) begin
         if (!taken_map[row][c]) begin
            if (seen == k) begin
               col   = c;
               found = 1'b1;
            end else begin
               seen++;
            end
         end
      end
      if (!found) begin
         return res;
      end
      taken_map[row][col] = 1'b1;
      free_in_row[row]--;
      if (free_in_row[row] == 0) begin
         open_rows--;
      end
      res.row    = ROW_W'(row);
      res.col    = COL_W'(col);
      res.status = STATUS_FLIPPED;
      return res;
   endfunction

   // Offer one item, with random idle cycles beforehand, and predict its result
   // once accepted. Valid is left high so that a following item can go straight on.
   task automatic send_item(input logic act, input logic [WORD_W-1:0] rw,
                            input logic [WORD_W-1:0] cw);
      cell_result_type predicted;
      while (!calm && $urandom_range(99) < 20) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.action          <= act;
      req_ch.random_row_word <= rw;
      req_ch.random_col_word <= cw;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      predicted = pick_free_cell(act, rw, cw);
      expected_cells.insert(expected_cells.size(), predicted);
      items_sent++;
   endtask

   // Stop offering items and wait until every result has come back.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_cells.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // One register write; valid stays high for a write that follows at once.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ch.ready);
      if (idx == REG_ROWS_IN_USE) begin
         row_setting = value;
         free_all_cells();
      end else if (idx == REG_COLS_IN_USE) begin
         col_setting = value;
         free_all_cells();
      end
   endtask

   // Set the grid size while idle, sometimes with a stray write to an unused index.
   task automatic configure(input logic [CSR_DATA_W-1:0] rows,
                            input logic [CSR_DATA_W-1:0] cols);
      wait_idle();
      write_register(REG_ROWS_IN_USE, rows);
      write_register(REG_COLS_IN_USE, cols);
      if ($urandom_range(5) == 0) begin
         write_register(CSR_IDX_W'($urandom_range(int'(REG_UNUSED_LOW), int'(REG_UNUSED_TOP))),
                        CSR_DATA_W'($urandom_range(63)));
      end
      csr_ch.valid <= 1'b0;
   endtask

   // Full-size grid after reset: word extremes and alternating bit patterns.
   task automatic test_default_grid();
      send_item(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
      send_item(ACT_FLIP, 16'h0000, 16'h0000);
      send_item(ACT_FLIP, 16'hFFFF, 16'hFFFF);
      send_item(ACT_FLIP, 16'h5555, 16'hAAAA);
      send_item(ACT_FLIP, 16'hAAAA, 16'h5555);
      send_item(ACT_FLIP, 16'h0000, 16'h0000);
   endtask

   // Smallest grids, a full grid, saturated registers and ignored indexes.
   task automatic test_grid_limits();
      // One cell: taken at once, then the grid reports full until cleared.
      configure(CSR_DATA_W'(1), CSR_DATA_W'(1));
      send_item(ACT_FLIP, 16'hFFFF, 16'h0000);
      send_item(ACT_FLIP, 16'h1234, 16'h4321);
      send_item(ACT_FLIP, 16'hFFFF, 16'hFFFF);
      send_item(ACT_CLEAR, 16'h0000, 16'h0000);
      send_item(ACT_FLIP, 16'h0000, 16'hFFFF);

      // Zero rows saturates to one, too many columns saturates to the maximum.
      configure(CSR_DATA_W'(0), CSR_DATA_W'(63));
      send_item(ACT_FLIP, 16'h0000, 16'hFFFF);
      send_item(ACT_FLIP, 16'hFFFF, 16'h001F);

      // Writes to indexes beyond the register list must leave the grid alone.
      wait_idle();
      write_register(REG_UNUSED_TOP, CSR_DATA_W'(63));
      write_register(REG_UNUSED_LOW, CSR_DATA_W'(0));
      csr_ch.valid <= 1'b0;
      send_item(ACT_FLIP, 16'h0000, 16'h0000);

      // One column of the maximum height, and both registers past the maximum.
      configure(CSR_DATA_W'(63), CSR_DATA_W'(0));
      send_item(ACT_FLIP, 16'hFFFF, 16'h0000);
      send_item(ACT_FLIP, 16'h0020, 16'hFFFF);
      configure(CSR_DATA_W'(33), CSR_DATA_W'(33));
      send_item(ACT_FLIP, 16'hFFFF, 16'hFFFF);

      // Fill a two by two grid completely, then flip once more.
      configure(CSR_DATA_W'(2), CSR_DATA_W'(2));
      for (int i = 0; i < 5; i++) begin
         send_item(ACT_FLIP, WORD_W'($urandom_range(65535)), WORD_W'($urandom_range(65535)));
      end
   endtask

   // Random grid sizes, each mostly filled up and past full, with stray clears.
   task automatic test_random_grids();
      logic [CSR_DATA_W-1:0] rows;
      logic [CSR_DATA_W-1:0] cols;
      int                    flips;
      while (items_sent < TOTAL_ITEMS) begin
         case ($urandom_range(9))
            0: begin
               rows = CSR_DATA_W'($urandom_range(1) ? 63 : $urandom_range(1));
               cols = CSR_DATA_W'($urandom_range(1) ? 33 : $urandom_range(1));
            end
            1: begin
               rows = CSR_DATA_W'(32);
               cols = CSR_DATA_W'($urandom_range(1, 2));
            end
            2: begin
               rows = CSR_DATA_W'($urandom_range(1, 2));
               cols = CSR_DATA_W'(32);
            end
            default: begin
               rows = CSR_DATA_W'($urandom_range(1, 6));
               cols = CSR_DATA_W'($urandom_range(1, 6));
            end
         endcase
         configure(rows, cols);

         // A stretch in the middle of the run runs without any idling.
         calm  = (items_sent > 250 && items_sent < 380);
         flips = clamp_dim(rows, MAX_ROWS) * clamp_dim(cols, MAX_COLS) + $urandom_range(3);
         if (flips > MAX_PHASE_FLIPS) begin
            flips = MAX_PHASE_FLIPS;
         end
         for (int i = 0; i < flips; i++) begin
            send_item(($urandom_range(99) < 4) ? ACT_CLEAR : ACT_FLIP,
                      WORD_W'($urandom_range(65535)), WORD_W'($urandom_range(65535)));
         end
         if ($urandom_range(1) == 0) begin
            send_item(ACT_CLEAR, WORD_W'($urandom_range(65535)), WORD_W'($urandom_range(65535)));
         end
      end
      calm = 1'b0;
   endtask

   // Compare each accepted result with the oldest prediction; the result side
   // stalls at random outside the calm stretch.
   always @(posedge clock) begin : check_results
      cell_result_type due;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_cells.size() == 0) begin
               $error("result with no item outstanding: row %0d col %0d status %0d",
                      rsp_ch.row_index, rsp_ch.col_index, rsp_ch.status);
               fail_count++;
            end else begin
               due = expected_cells.pop_front();
               if (rsp_ch.row_index !== due.row) begin
                  $error("row_index: expected %0d, got %0d", due.row, rsp_ch.row_index);
                  fail_count++;
               end
               if (rsp_ch.col_index !== due.col) begin
                  $error("col_index: expected %0d, got %0d", due.col, rsp_ch.col_index);
                  fail_count++;
               end
               if (rsp_ch.status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_ch.status);
                  fail_count++;
               end
            end
         end
         rsp_ch.ready <= calm || ($urandom_range(99) >= 20);
      end
   end

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog for a hung run.
   initial begin
      #(10_000_000);
      $display("tb_random_free_cell_picker_top NOT OK");
      $finish;
   end

   // Reset, the tests in turn, then drain and report.
   initial begin
      reset                  = 1'b1;
      calm                   = 1'b0;
      fail_count             = 0;
      items_sent             = 0;
      req_ch.valid           = 1'b0;
      req_ch.action          = ACT_FLIP;
      req_ch.random_row_word = '0;
      req_ch.random_col_word = '0;
      rsp_ch.ready           = 1'b0;
      csr_ch.valid           = 1'b0;
      csr_ch.index           = REG_ROWS_IN_USE;
      csr_ch.data            = '0;
      row_setting            = CNT_W'(MAX_ROWS);
      col_setting            = CNT_W'(MAX_COLS);
      free_all_cells();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_default_grid();
      test_grid_limits();
      test_random_grids();

      wait_idle();
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_random_free_cell_picker_top OK");
      end else begin
         $display("tb_random_free_cell_picker_top NOT OK");
      end
      $finish;
   end

endmodule
